@@ src/m4vt_pkg.sv @@
// Shared types and constants for the 4x4 matrix vector transform core.
// No dependencies; the interfaces, the dot lane and the core import this package.
package m4vt_pkg;

  localparam int unsigned NUM_ELEMS = 4;
  localparam int unsigned NUM_COEFS = NUM_ELEMS * NUM_ELEMS;

  typedef logic signed [31:0] coef_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [64:0] psum_t;
  typedef logic signed [65:0] sum_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  localparam coef_t SAT_MAX = 32'sh7fff_ffff;
  localparam coef_t SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

@@ src/m4vt_stream_if.sv @@
// Valid/ready stream interfaces for the command and result channels.
// Depends on m4vt_pkg for the payload types.
interface m4vt_cmd_if;
  import m4vt_pkg::*;

  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  coef_source;
  logic [1:0]  coef_target;
  coef_t       coef_value;
  coef_t       vec_x;
  coef_t       vec_y;
  coef_t       vec_z;
  coef_t       vec_w;

  modport source (
    output valid, action, coef_source, coef_target, coef_value,
    output vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, action, coef_source, coef_target, coef_value,
    input  vec_x, vec_y, vec_z, vec_w,
    output ready
  );
  modport mon (
    input valid, ready, action, coef_source, coef_target, coef_value,
    input vec_x, vec_y, vec_z, vec_w
  );
endinterface

interface m4vt_res_if;
  import m4vt_pkg::*;

  logic  valid;
  logic  ready;
  coef_t out_x;
  coef_t out_y;
  coef_t out_z;
  coef_t out_w;
  logic  overflow;

  modport source (
    output valid, out_x, out_y, out_z, out_w, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, overflow,
    output ready
  );
  modport mon (
    input valid, ready, out_x, out_y, out_z, out_w, overflow
  );
endinterface

@@ src/m4vt_dot_lane.sv @@
// One output component: four products, a two-level adder tree, then shift and saturate.
// Depends on m4vt_pkg; stage enables come from the top level.
module m4vt_dot_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  m4vt_pkg::stage_en_t en,
  input  m4vt_pkg::coef_t    col [m4vt_pkg::NUM_ELEMS],
  input  m4vt_pkg::coef_t    vec [m4vt_pkg::NUM_ELEMS],
  output m4vt_pkg::coef_t    result,
  output logic               sat
);
  import m4vt_pkg::*;

  prod_t prod [NUM_ELEMS];
  psum_t psum [2];
  sum_t  total;
  sum_t  shifted;
  logic  sat_hi;
  logic  sat_lo;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
        prod[k] <= prod_t'(col[k]) * prod_t'(vec[k]);
      end
    end
    if (en.s2) begin
      psum[0] <= psum_t'(prod[0]) + psum_t'(prod[1]);
      psum[1] <= psum_t'(prod[2]) + psum_t'(prod[3]);
    end
    if (en.s3) begin
      total <= sum_t'(psum[0]) + sum_t'(psum[1]);
    end
    if (en.s4) begin
      result <= sat_hi ? SAT_MAX : (sat_lo ? SAT_MIN : shifted[31:0]);
      sat    <= sat_hi | sat_lo;
    end
  end

  // The shift is arithmetic, so the result rounds toward minus infinity.
  always_comb begin
    shifted = total >>> FRAC_BITS;
    sat_hi  = !shifted[65] && (|shifted[64:31]);
    sat_lo  = shifted[65] && !(&shifted[64:31]);
  end

endmodule

@@ src/matrix4_vector_transform_core.sv @@
// 4x4 matrix by vector transform in signed fixed point, four register stages deep.
// One item per cycle is accepted unless a stalled result backs up the pipeline.
// The multipliers, the two adder levels and the saturating shift each take one stage.
// A load item updates the matrix at once and is seen by the next item; it gives no result.
// Synchronous reset clears the matrix to zero and empties the pipeline.
// Depends on m4vt_pkg, m4vt_stream_if and m4vt_dot_lane.
module matrix4_vector_transform_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  m4vt_cmd_if.sink   cmd,
  m4vt_res_if.source res
);
  import m4vt_pkg::*;

  coef_t     coef [NUM_COEFS];
  coef_t     vec  [NUM_ELEMS];
  coef_t     lane_res [NUM_ELEMS];
  logic [NUM_ELEMS-1:0] lane_sat;
  logic      v1, v2, v3, v4;
  logic      adv1, adv2, adv3, adv4;
  logic      accept;
  stage_en_t en;

  assign adv4   = !v4 || res.ready;
  assign adv3   = !v3 || adv4;
  assign adv2   = !v2 || adv3;
  assign adv1   = !v1 || adv2;
  assign accept = cmd.valid && adv1;

  assign en.s1 = adv1;
  assign en.s2 = adv2;
  assign en.s3 = adv3;
  assign en.s4 = adv4;

  assign cmd.ready = adv1;

  assign vec[0] = cmd.vec_x;
  assign vec[1] = cmd.vec_y;
  assign vec[2] = cmd.vec_z;
  assign vec[3] = cmd.vec_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef[i] <= '0;
      end
    end else if (accept && cmd.action == ACT_LOAD) begin
      coef[{cmd.coef_source, cmd.coef_target}] <= cmd.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= cmd.valid && cmd.action == ACT_XFORM;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  for (genvar r = 0; r < NUM_ELEMS; r++) begin : g_lane
    coef_t col [NUM_ELEMS];

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_col
      assign col[k] = coef[k * NUM_ELEMS + r];
    end

    m4vt_dot_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .col   (col),
      .vec   (vec),
      .result(lane_res[r]),
      .sat   (lane_sat[r])
    );
  end

  assign res.valid    = v4;
  assign res.out_x    = lane_res[0];
  assign res.out_y    = lane_res[1];
  assign res.out_z    = lane_res[2];
  assign res.out_w    = lane_res[3];
  assign res.overflow = |lane_sat;

endmodule

@@ src/m4vt_checker.sv @@
// Port-level assertions for the transform core, attached to it by the bind below.
// Depends on m4vt_stream_if.
module m4vt_checker (
  input logic        clk,
  input logic        rst,
  m4vt_cmd_if.sink   cmd,
  m4vt_res_if.source res
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid straight after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid)
    else $error("result item dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> $stable(res.out_x) && $stable(res.out_y) &&
      $stable(res.out_z) && $stable(res.out_w) && $stable(res.overflow))
    else $error("stalled result item changed");

  // The command side only backs up when every stage holds an item and the output is stalled.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> res.valid && !res.ready)
    else $error("command stalled without a full pipeline");

endmodule

bind matrix4_vector_transform_core m4vt_checker u_m4vt_checker (
  .clk(clk),
  .rst(rst),
  .cmd(cmd),
  .res(res)
);
